/* hdl/pcpt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpt_pkg - shared definitions for the polar/Cartesian point tracker
// Field widths, mode codes, the CORDIC arctangent table and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pcpt_pkg;

  // Field and datapath widths.
  localparam int COORD_W    = 48;
  localparam int ANGLE_W    = 32;
  localparam int CW         = 64;   // CORDIC working width
  localparam int GUARD      = 8;    // guard bits below the Q23.24 point
  localparam int MODE_W     = 3;
  localparam int IN_DATA_W  = 104;  // 99 bits of fields, padded to bytes
  localparam int OUT_DATA_W = 96;

  // Iteration count, limited by the length of the arctangent table.
  localparam int CORDIC_STEPS = 32;
  localparam int TABLE_LEN    = 48;
  localparam int STEP_N       = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int STEP_W       = $clog2(STEP_N);
  localparam int TAB_W        = 6;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_START = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_X = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADD_Y = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ADD_R = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ADD_A = 3'd4;

  // Gain correction sub-steps.
  localparam logic [1:0] GPH_LO  = 2'd0;
  localparam logic [1:0] GPH_HI  = 2'd1;
  localparam logic [1:0] GPH_SUM = 2'd2;
  localparam logic [1:0] GPH_OUT = 2'd3;

  // Inverse CORDIC gain, 2^-32 units.
  localparam logic [31:0] GAIN_INV = 32'h9B74_EDA8;

  localparam logic signed [COORD_W-1:0] MAX48 = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] MIN48 = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic              load;   // accept a request and apply its update
    logic              prep;   // seed the CORDIC registers or take a shortcut
    logic              iter;   // one CORDIC micro-rotation
    logic [STEP_W-1:0] step;   // iteration index
    logic              gain;   // one gain correction sub-step
    logic [1:0]        phase;  // gain sub-step code
    logic              gsel;   // 0: correct cx, 1: correct cy
    logic              emit;   // load the result register
  } pcpt_cmd_t;

  typedef struct packed {
    logic is_cart;   // request updates the Cartesian form
    logic skip;      // no CORDIC pass needed
    logic out_free;  // result register can take a new result
  } pcpt_stat_t;

  // floor(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic [ANGLE_W-1:0] atan_lut(input logic [TAB_W-1:0] idx);
    logic [ANGLE_W-1:0] a;
    case (idx)
      6'd0:  a = 32'h2000_0000;
      6'd1:  a = 32'h12E4_051D;
      6'd2:  a = 32'h09FB_385B;
      6'd3:  a = 32'h0511_11D4;
      6'd4:  a = 32'h028B_0D43;
      6'd5:  a = 32'h0145_D7E1;
      6'd6:  a = 32'h00A2_F61E;
      6'd7:  a = 32'h0051_7C55;
      6'd8:  a = 32'h0028_BE53;
      6'd9:  a = 32'h0014_5F2E;
      6'd10: a = 32'h000A_2F98;
      6'd11: a = 32'h0005_17CC;
      6'd12: a = 32'h0002_8BE6;
      6'd13: a = 32'h0001_45F3;
      6'd14: a = 32'h0000_A2F9;
      6'd15: a = 32'h0000_517C;
      6'd16: a = 32'h0000_28BE;
      6'd17: a = 32'h0000_145F;
      6'd18: a = 32'h0000_0A2F;
      6'd19: a = 32'h0000_0517;
      6'd20: a = 32'h0000_028B;
      6'd21: a = 32'h0000_0145;
      6'd22: a = 32'h0000_00A2;
      6'd23: a = 32'h0000_0051;
      6'd24: a = 32'h0000_0028;
      6'd25: a = 32'h0000_0014;
      6'd26: a = 32'h0000_000A;
      6'd27: a = 32'h0000_0005;
      6'd28: a = 32'h0000_0002;
      6'd29: a = 32'h0000_0001;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Clamp a 49-bit signed sum into the 48-bit signed range.
  function automatic logic signed [COORD_W-1:0] sat49(input logic signed [COORD_W:0] s);
    logic signed [COORD_W-1:0] r;
    if (s[COORD_W] != s[COORD_W-1]) begin
      r = s[COORD_W] ? MIN48 : MAX48;
    end else begin
      r = s[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/pcpt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpt_ctrl - sequencer for the point tracker
// Walks each request through seeding, the CORDIC iterations, gain correction
// and hand-off to the result register, or from seeding straight to hand-off.
// ----------------------------------------------------------------------------
module pcpt_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  pcpt_pkg::pcpt_stat_t   stat,
  output pcpt_pkg::pcpt_cmd_t    cmd
);
  import pcpt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_ITER = 3'd2;
  localparam logic [2:0] S_GAIN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic              gsel_r, gsel_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.load  = in_tvalid && (state_r == S_IDLE);
    cmd.prep  = (state_r == S_PREP);
    cmd.iter  = (state_r == S_ITER);
    cmd.step  = step_r;
    cmd.gain  = (state_r == S_GAIN);
    cmd.phase = phase_r;
    cmd.gsel  = gsel_r;
    cmd.emit  = (state_r == S_DONE) && stat.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    phase_nxt = phase_r;
    gsel_nxt  = gsel_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        step_nxt = '0;
        if (stat.skip) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ITER;
        end
      end
      S_ITER: begin
        if (step_r == STEP_W'(STEP_N - 1)) begin
          state_nxt = S_GAIN;
          phase_nxt = GPH_LO;
          gsel_nxt  = 1'b0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_GAIN: begin
        if (phase_r == GPH_OUT) begin
          phase_nxt = GPH_LO;
          if (stat.is_cart && !gsel_r) begin
            gsel_nxt = 1'b1;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          phase_nxt = phase_r + 1'b1;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      phase_r <= GPH_LO;
      gsel_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
      gsel_r  <= gsel_nxt;
    end
  end

endmodule

/* hdl/pcpt_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpt_datapath - point state, shared CORDIC stage and gain multiplier
// Holds the point in both forms, runs one micro-rotation per cycle and
// applies the inverse gain with one 32x32 multiplier, low half then high half.
// ----------------------------------------------------------------------------
module pcpt_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [pcpt_pkg::IN_DATA_W-1:0]    in_tdata,
  input  pcpt_pkg::pcpt_cmd_t               cmd,
  output pcpt_pkg::pcpt_stat_t              stat,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pcpt_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import pcpt_pkg::*;

  // Request fields.
  logic [MODE_W-1:0]         in_mode;
  logic signed [COORD_W-1:0] in_value, in_second;
  assign in_mode   = in_tdata[MODE_W-1:0];
  assign in_value  = in_tdata[MODE_W+COORD_W-1:MODE_W];
  assign in_second = in_tdata[MODE_W+2*COORD_W-1:MODE_W+COORD_W];

  logic [MODE_W-1:0]         mode_r;
  logic signed [COORD_W-1:0] coord_x_r, coord_x_nxt;
  logic signed [COORD_W-1:0] coord_y_r, coord_y_nxt;
  logic signed [COORD_W-1:0] radius_r, radius_nxt;
  logic [ANGLE_W-1:0]        angle_r, angle_nxt;
  logic signed [CW-1:0]      cx_r, cx_nxt, cy_r, cy_nxt;
  logic [ANGLE_W-1:0]        z_r, z_nxt;
  logic                      gneg_r;
  logic [CW-1:0]             mul_r;
  logic [32:0]               lo_part_r;
  logic [CW-1:0]             q_r;
  logic                      out_valid_r;
  logic [OUT_DATA_W-1:0]     out_data_r;

  logic is_polar, is_cart, is_none, x_zero, y_zero;
  assign is_polar = (mode_r == MODE_START) || (mode_r == MODE_ADD_X) ||
                    (mode_r == MODE_ADD_Y);
  assign is_cart  = (mode_r == MODE_ADD_R) || (mode_r == MODE_ADD_A);
  assign is_none  = !is_polar && !is_cart;
  assign x_zero   = (coord_x_r == '0);
  assign y_zero   = (coord_y_r == '0);

  assign stat.is_cart  = is_cart;
  assign stat.skip     = is_none || (is_polar && (x_zero || y_zero));
  assign stat.out_free = !out_valid_r || out_tready;

  function automatic logic signed [COORD_W-1:0] abs_sat(input logic signed [COORD_W-1:0] v);
    logic signed [COORD_W:0] e;
    e = {v[COORD_W-1], v};
    return sat49(v[COORD_W-1] ? -e : e);
  endfunction

  // CORDIC stage.
  logic [TAB_W-1:0]     shamt;
  logic signed [CW-1:0] xsh, ysh;
  logic                 rot_pos;
  logic [ANGLE_W-1:0]   atan_v;
  assign shamt   = TAB_W'(cmd.step);
  assign xsh     = cx_r >>> shamt;
  assign ysh     = cy_r >>> shamt;
  assign atan_v  = atan_lut(shamt);
  assign rot_pos = is_cart ? !z_r[ANGLE_W-1] : cy_r[CW-1];

  // Gain correction operands.
  logic signed [CW-1:0] gsrc;
  logic [CW-1:0]        gmag;
  logic [31:0]          mul_op;
  logic [CW-1:0]        prod;
  logic [CW-1:0]        q_rnd;
  logic signed [COORD_W-1:0] gres;
  assign gsrc   = cmd.gsel ? cy_r : cx_r;
  assign gmag   = gsrc[CW-1] ? CW'(-gsrc) : CW'(gsrc);
  assign mul_op = (cmd.phase == GPH_LO) ? gmag[31:0] : gmag[CW-1:32];
  assign prod   = mul_op * GAIN_INV;
  assign q_rnd  = (q_r + CW'(1 << (GUARD - 1))) >> GUARD;

  always_comb begin
    if (!gneg_r) begin
      gres = (q_rnd > CW'(MAX48)) ? MAX48 : q_rnd[COORD_W-1:0];
    end else begin
      gres = (q_rnd > (CW'(1) << (COORD_W - 1))) ? MIN48 : -q_rnd[COORD_W-1:0];
    end
  end

  // Architectural state and CORDIC registers.
  logic signed [CW-1:0] seed_x, seed_y, seed_r;
  assign seed_x = CW'(coord_x_r) <<< GUARD;
  assign seed_y = CW'(coord_y_r) <<< GUARD;
  assign seed_r = CW'(radius_r) <<< GUARD;

  logic [ANGLE_W-1:0] quarter_sum;
  assign quarter_sum = angle_r + 32'h4000_0000;

  always_comb begin
    coord_x_nxt = coord_x_r;
    coord_y_nxt = coord_y_r;
    radius_nxt  = radius_r;
    angle_nxt   = angle_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    z_nxt       = z_r;
    if (cmd.load) begin
      case (in_mode)
        MODE_START: begin
          coord_x_nxt = in_value;
          coord_y_nxt = in_second;
        end
        MODE_ADD_X: coord_x_nxt = sat49({coord_x_r[COORD_W-1], coord_x_r} +
                                        {in_value[COORD_W-1], in_value});
        MODE_ADD_Y: coord_y_nxt = sat49({coord_y_r[COORD_W-1], coord_y_r} +
                                        {in_value[COORD_W-1], in_value});
        MODE_ADD_R: radius_nxt  = sat49({radius_r[COORD_W-1], radius_r} +
                                        {in_value[COORD_W-1], in_value});
        MODE_ADD_A: angle_nxt   = angle_r + in_value[ANGLE_W-1:0];
        default: ;
      endcase
    end else if (cmd.prep) begin
      if (is_polar) begin
        if (x_zero && y_zero) begin
          radius_nxt = '0;
          angle_nxt  = '0;
        end else if (x_zero) begin
          radius_nxt = abs_sat(coord_y_r);
          angle_nxt  = coord_y_r[COORD_W-1] ? 32'hC000_0000 : 32'h4000_0000;
        end else if (y_zero) begin
          radius_nxt = abs_sat(coord_x_r);
          angle_nxt  = coord_x_r[COORD_W-1] ? 32'h8000_0000 : 32'h0000_0000;
        end
        // Left half plane: mirror through the origin and start at pi.
        if (coord_x_r[COORD_W-1]) begin
          cx_nxt = -seed_x;
          cy_nxt = -seed_y;
          z_nxt  = 32'h8000_0000;
        end else begin
          cx_nxt = seed_x;
          cy_nxt = seed_y;
          z_nxt  = '0;
        end
      end else begin
        cy_nxt = '0;
        // Angle in the left half plane: negate and rotate back by pi.
        if (quarter_sum[ANGLE_W-1]) begin
          cx_nxt = -seed_r;
          z_nxt  = angle_r ^ 32'h8000_0000;
        end else begin
          cx_nxt = seed_r;
          z_nxt  = angle_r;
        end
      end
    end else if (cmd.iter) begin
      if (rot_pos) begin
        cx_nxt = cx_r - ysh;
        cy_nxt = cy_r + xsh;
        z_nxt  = z_r - atan_v;
      end else begin
        cx_nxt = cx_r + ysh;
        cy_nxt = cy_r - xsh;
        z_nxt  = z_r + atan_v;
      end
    end else if (cmd.gain && (cmd.phase == GPH_OUT)) begin
      if (is_cart) begin
        if (cmd.gsel) begin
          coord_y_nxt = gres;
        end else begin
          coord_x_nxt = gres;
        end
      end else begin
        radius_nxt = gres;
        angle_nxt  = z_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_x_r   <= '0;
      coord_y_r   <= '0;
      radius_r    <= '0;
      angle_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      coord_x_r <= coord_x_nxt;
      coord_y_r <= coord_y_nxt;
      radius_r  <= radius_nxt;
      angle_r   <= angle_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    z_r  <= z_nxt;
    if (cmd.load) begin
      mode_r <= in_mode;
    end
    if (cmd.gain) begin
      case (cmd.phase)
        GPH_LO: begin
          mul_r  <= prod;
          gneg_r <= gsrc[CW-1];
        end
        GPH_HI: begin
          lo_part_r <= 33'((mul_r + CW'(32'h8000_0000)) >> 32);
          mul_r     <= prod;
        end
        GPH_SUM: q_r <= mul_r + CW'(lo_part_r);
        default: ;
      endcase
    end
    if (cmd.emit) begin
      out_data_r <= {coord_y_nxt, coord_x_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* hdl/polar_cartesian_point_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_cartesian_point_tracker - point kept in Cartesian and polar form
// Each request loads or nudges the point; the other form is recomputed with
// an iterative CORDIC and the current x and y are returned.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Payload
//   --------+-----------+------------------------------------------------------
//   in_     | slave     | tdata: mode[2:0], value[50:3], second_value[98:51]
//   out_    | master    | tdata: out_x[47:0], out_y[95:48]
//
// One request is in flight at a time. A request that changes x or y passes
// from acceptance through seeding, the CORDIC iterations and gain correction
// of the radius to hand-off at the result register; one that changes radius
// or angle has two gain corrections, as the gain multiplier corrects x and y
// in turn. A request that changes x or y and lands on an axis or the origin,
// or an unused mode, goes from seeding straight to hand-off. The next request
// is taken in the cycle after hand-off. Reset is synchronous and active low
// and zeroes the point. A stalled result sits in the output register while
// the next request is accepted and worked on; only its hand-off waits for the
// register to drain.
module polar_cartesian_point_tracker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // mode[2:0], value[50:3], second_value[98:51], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata   // out_x[47:0], out_y[95:48]
);
  import pcpt_pkg::*;

  // Commands from the sequencer and status back from the datapath.
  pcpt_cmd_t  cmd;
  pcpt_stat_t stat;

  // The sequencer owns the request handshake; the datapath owns the result
  // register and reports when it can take a new result.
  pcpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Point state, the CORDIC stage and the gain multiplier.
  pcpt_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
